// ===== hw/rtl/huffman_tree_walk_decoder_macros.svh =====
// assertion macros used by the huffman tree walk decoder rtl
`ifndef HUFFMAN_TREE_WALK_DECODER_MACROS_SVH
`define HUFFMAN_TREE_WALK_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define HTWD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HTWD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/htwd_pkg.sv =====
// shared constants and types of the huffman tree walk decoder
package htwd_pkg;

  localparam int unsigned IDX_W    = 9;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned MAX_BITS = 8;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_DECODE  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // one decoded symbol handed from the walker to the output register
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } push_t;

endpackage

// ===== hw/rtl/htwd_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module htwd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/htwd_walk.sv =====
// tree walker: node table, walk state and per-bit sequencing
`include "huffman_tree_walk_decoder_macros.svh"

module htwd_walk #(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [htwd_pkg::IDX_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [htwd_pkg::IDX_W-1:0]   node_index_i,
  input  logic [htwd_pkg::IDX_W-1:0]   left_child_i,
  input  logic [htwd_pkg::IDX_W-1:0]   right_child_i,
  input  logic [htwd_pkg::SYM_W-1:0]   leaf_symbol_i,
  input  logic                         is_leaf_i,
  input  logic [htwd_pkg::BYTE_W-1:0]  code_byte_i,
  input  logic [htwd_pkg::CNT_W-1:0]   bit_count_i,
  output htwd_pkg::push_t              push_o,
  input  logic                         push_ready_i
);

  localparam int SymKeep = (SYMBOL_BITS < 8) ? SYMBOL_BITS : 8;
  localparam int IdxW    = htwd_pkg::IDX_W;
  localparam int EntryW  = 2 * IdxW + SymKeep + 1;
  localparam int AddrW   = $clog2(NODE_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESUME,
    S_WALK,
    S_FLUSH
  } state_e;

  state_e                          state_q, state_d;
  logic [IdxW-1:0]                 root_q;
  logic [IdxW-1:0]                 cur_q, cur_d;
  logic                            at_start_q, at_start_d;
  logic [htwd_pkg::BYTE_W-1:0]     bits_q, bits_d;
  logic [htwd_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                            pend_v_q, pend_v_d;
  logic [SymKeep-1:0]              pend_sym_q, pend_sym_d;
  logic                            oob_q;

  logic                            ram_we;
  logic                            ram_re;
  logic [IdxW-1:0]                 rd_idx;
  logic [EntryW-1:0]               ram_wdata;
  logic [EntryW-1:0]               ram_rdata;
  logic [EntryW-1:0]               entry;
  logic [IdxW-1:0]                 e_left;
  logic [IdxW-1:0]                 e_right;
  logic [SymKeep-1:0]              e_sym;
  logic                            e_leaf;
  logic [htwd_pkg::CNT_W-1:0]      cnt_sat;
  logic                            hit;
  logic                            start;

  function automatic logic idx_oob(logic [IdxW-1:0] idx);
    return {{(32 - IdxW){1'b0}}, idx} >= 32'(NODE_COUNT);
  endfunction

  htwd_ram #(
    .WIDTH (EntryW),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(node_index_i)),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (AddrW'(rd_idx)),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = {is_leaf_i, leaf_symbol_i[SymKeep-1:0], right_child_i, left_child_i};

  // an index past the table reads as an all-zero node
  assign entry   = oob_q ? '0 : ram_rdata;
  assign e_left  = entry[IdxW-1:0];
  assign e_right = entry[2*IdxW-1:IdxW];
  assign e_sym   = entry[2*IdxW +: SymKeep];
  assign e_leaf  = entry[EntryW-1];

  assign cnt_sat = (bit_count_i > htwd_pkg::CNT_W'(htwd_pkg::MAX_BITS))
                 ? htwd_pkg::CNT_W'(htwd_pkg::MAX_BITS) : bit_count_i;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    at_start_d = at_start_q;
    bits_d     = bits_q;
    cnt_d      = cnt_q;
    pend_v_d   = pend_v_q;
    pend_sym_d = pend_sym_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    rd_idx     = cur_q;
    push_o     = '0;
    hit        = 1'b0;
    start      = at_start_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_i)
            htwd_pkg::OP_WRITE: begin
              ram_we = !idx_oob(node_index_i);
            end
            htwd_pkg::OP_RESTART: begin
              cur_d      = '0;
              at_start_d = 1'b1;
            end
            htwd_pkg::OP_DECODE: begin
              bits_d = code_byte_i;
              cnt_d  = cnt_sat;
              if (cnt_sat != '0) begin
                ram_re = 1'b1;
                if (at_start_q) begin
                  // first bit of a code is skipped, walk sits at the root
                  rd_idx     = root_q;
                  cur_d      = root_q;
                  at_start_d = 1'b0;
                  bits_d     = code_byte_i >> 1;
                  cnt_d      = cnt_sat - 1'b1;
                  state_d    = S_WALK;
                end else begin
                  // refetch the node where the previous word stopped
                  rd_idx  = cur_q;
                  state_d = S_RESUME;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RESUME, S_WALK: begin
        hit = (state_q == S_WALK) && e_leaf;
        if (!(hit && pend_v_q && !push_ready_i)) begin
          if (hit) begin
            push_o.valid  = pend_v_q;
            push_o.symbol = htwd_pkg::SYM_W'(pend_sym_q);
            push_o.last   = 1'b0;
            pend_v_d      = 1'b1;
            pend_sym_d    = e_sym;
            start         = 1'b1;
            cur_d         = '0;
          end
          if (cnt_q != '0) begin
            rd_idx     = start ? root_q : (bits_q[0] ? e_right : e_left);
            ram_re     = 1'b1;
            cur_d      = rd_idx;
            at_start_d = 1'b0;
            bits_d     = bits_q >> 1;
            cnt_d      = cnt_q - 1'b1;
            state_d    = S_WALK;
          end else begin
            at_start_d = start;
            state_d    = (hit || pend_v_q) ? S_FLUSH : S_IDLE;
          end
        end
      end
      S_FLUSH: begin
        if (push_ready_i) begin
          push_o.valid  = 1'b1;
          push_o.symbol = htwd_pkg::SYM_W'(pend_sym_q);
          push_o.last   = 1'b1;
          pend_v_d      = 1'b0;
          state_d       = S_IDLE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      root_q     <= '0;
      cur_q      <= '0;
      at_start_q <= 1'b1;
      cnt_q      <= '0;
      pend_v_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      at_start_q <= at_start_d;
      cnt_q      <= cnt_d;
      pend_v_q   <= pend_v_d;
      if (cfg_we_i) begin
        root_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bits_q     <= bits_d;
    pend_sym_q <= pend_sym_d;
    if (ram_re) begin
      oob_q <= idx_oob(rd_idx);
    end
  end

  `HTWD_ASSERT_IMP(a_push_has_room, clk_i, rst_ni, push_o.valid, push_ready_i,
    "symbol pushed while output register is full")
  `HTWD_ASSERT_IMP(a_pend_busy, clk_i, rst_ni, pend_v_q, in_stall_o,
    "pending symbol while walker accepts words")
  `HTWD_ASSERT_IMP(a_walk_in_code, clk_i, rst_ni,
    (state_q == S_WALK) || (state_q == S_RESUME), !at_start_q,
    "walk step with code start flag set")
  `HTWD_ASSERT_IMP(a_last_on_flush, clk_i, rst_ni, push_o.valid && push_o.last,
    state_q == S_FLUSH, "last symbol pushed outside flush")
  `HTWD_ASSERT_NXT(a_flush_done, clk_i, rst_ni,
    (state_q == S_FLUSH) && push_ready_i, !pend_v_q,
    "pending symbol left after flush")

endmodule

// ===== hw/rtl/htwd_out.sv =====
// output register between the walker and the result channel
module htwd_out (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  htwd_pkg::push_t             push_i,
  output logic                        push_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [htwd_pkg::SYM_W-1:0]  symbol_o,
  output logic                        last_o
);

  logic                       valid_q;
  logic [htwd_pkg::SYM_W-1:0] symbol_q;
  logic                       last_q;

  assign push_ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (push_i.valid) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      symbol_q <= push_i.symbol;
      last_q   <= push_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign symbol_o    = symbol_q;
  assign last_o      = last_q;

endmodule

// ===== hw/rtl/huffman_tree_walk_decoder.sv =====
// huffman tree walk decoder: one node-table read per code bit, symbols out in order
// write and restart words complete in the idle state; a decode word reads one node
// per bit (plus a refetch of the current node inside a code), then hands off its
// last symbol in a flush step; output stalls hold the walk at the next leaf
// reset clears the walk to a code start and the root register to zero; the node
// table is not cleared and must be written before it is walked
module huffman_tree_walk_decoder #(
  parameter int NODE_COUNT  = 512,
  parameter int SYMBOL_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [htwd_pkg::IDX_W-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   op_i,
  input  logic [htwd_pkg::IDX_W-1:0]   node_index_i,
  input  logic [htwd_pkg::IDX_W-1:0]   left_child_i,
  input  logic [htwd_pkg::IDX_W-1:0]   right_child_i,
  input  logic [htwd_pkg::SYM_W-1:0]   leaf_symbol_i,
  input  logic                         is_leaf_i,
  input  logic [htwd_pkg::BYTE_W-1:0]  code_byte_i,
  input  logic [htwd_pkg::CNT_W-1:0]   bit_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [htwd_pkg::SYM_W-1:0]   symbol_o,
  output logic                         last_o
);

  htwd_pkg::push_t push;
  logic            push_ready;

  htwd_walk #(
    .NODE_COUNT  (NODE_COUNT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_walk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .node_index_i  (node_index_i),
    .left_child_i  (left_child_i),
    .right_child_i (right_child_i),
    .leaf_symbol_i (leaf_symbol_i),
    .is_leaf_i     (is_leaf_i),
    .code_byte_i   (code_byte_i),
    .bit_count_i   (bit_count_i),
    .push_o        (push),
    .push_ready_i  (push_ready)
  );

  htwd_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .symbol_o     (symbol_o),
    .last_o       (last_o)
  );

endmodule
